// ----- rtl/assert_macros.svh -----
// Shared assertion macros for the row dequantizer checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/erd_pkg.sv -----
package erd_pkg;

    typedef enum logic [1:0] {
        FMT_F32 = 2'd0,
        FMT_F16 = 2'd1,
        FMT_Q8  = 2'd2,
        FMT_Q4  = 2'd3
    } fmt_t;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_ROWLEN = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;

    localparam logic [13:0] ROWLEN_RESET = 14'd32;

    typedef struct packed {
        fmt_t        format_mode;
        logic [13:0] row_length;
        logic [17:0] scale_base;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_RDW,
        ST_RDS0,
        ST_RDS1,
        ST_FIN
    } state_t;

    // exact fp32 bits of q times fp16 h
    function automatic logic [31:0] scale_mul(input logic signed [8:0] q,
                                              input logic [15:0] h);
        logic        s;
        logic [4:0]  ex;
        logic [9:0]  m;
        logic        qneg;
        logic signed [8:0] qn;
        logic [7:0]  qa;
        logic        sign;
        logic [10:0] mant;
        logic [18:0] pb;
        logic [4:0]  p;
        logic [7:0]  expo;
        logic [41:0] frac;
        s    = h[15];
        ex   = h[14:10];
        m    = h[9:0];
        qneg = q[8];
        qn   = -q;
        qa   = qneg ? qn[7:0] : q[7:0];
        sign = s ^ qneg;
        if (ex == 5'd31) begin
            if (m != 10'd0) begin
                return {s, 8'hFF, 1'b1, m[8:0], 13'd0};
            end
            if (qa == 8'd0) begin
                return 32'h7FC00000;
            end
            return {sign, 8'hFF, 23'd0};
        end
        mant = (ex == 5'd0) ? {1'b0, m} : {1'b1, m};
        pb   = 19'(mant) * 19'(qa);
        if (pb == 19'd0) begin
            return {sign, 31'd0};
        end
        p = 5'd0;
        for (int k = 0; k < 19; k++) begin
            if (pb[k]) begin
                p = 5'(k);
            end
        end
        expo = (ex == 5'd0) ? (8'(p) + 8'd103) : (8'(p) + 8'(ex) + 8'd102);
        frac = 42'(pb) << (5'd23 - p);
        return {sign, expo, frac[22:0]};
    endfunction

endpackage

// ----- rtl/erd_store.sv -----
module erd_store #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/erd_cfg.sv -----
module erd_cfg
    import erd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr;

    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.format_mode <= FMT_F32;
            cfg_reg.row_length  <= ROWLEN_RESET;
            cfg_reg.scale_base  <= 18'd0;
        end else if (wr) begin
            case (paddr[3:2])
                REG_FORMAT: cfg_reg.format_mode <= fmt_t'(pwdata[1:0]);
                REG_ROWLEN: cfg_reg.row_length  <= pwdata[13:0];
                REG_SCALE:  cfg_reg.scale_base  <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT: prdata = {30'd0, cfg_reg.format_mode};
            REG_ROWLEN: prdata = {18'd0, cfg_reg.row_length};
            REG_SCALE:  prdata = {14'd0, cfg_reg.scale_base};
            default:    prdata = 32'd0;
        endcase
    end

endmodule

// ----- rtl/embedding_row_dequantizer.sv -----
// Embedding row dequantizer.
// Input channel (s_*): action 1 writes s_word_data to store word s_word_address
// (no result); action 0 looks up group s_group of row s_token and
// returns its elements, in order, on the m_* channel as fp32 bit patterns,
// with m_last on the final element and m_fault when a needed byte lies
// beyond the store (value then zero).
// APB port sets format_mode (0x0), row_length (0x4), scale_base (0x8);
// write it only while the block is idle.
// Sequencing: a lookup runs a setup state (ST_BASE), then for each element
// one weight-word read and two scale-word reads on the single store port,
// then the decode (ST_RDW, ST_RDS0, ST_RDS1, ST_FIN).
// The result register lets the next request be taken while the last result
// of a group still waits; a stalled receiver holds the decode stage.
// Reset clears control state, output valid and the config registers; datapath
// registers and store stay undefined until loaded; there is no clearing pass.
module embedding_row_dequantizer
    import erd_pkg::*;
#(
    parameter int STORE_WORDS = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [15:0] s_word_address,
    input  logic [31:0] s_word_data,
    input  logic [15:0] s_token,
    input  logic [7:0]  s_group,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic [12:0] m_element,
    output logic        m_last,
    output logic        m_fault,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam logic [31:0] SW = 32'(STORE_WORDS);

    cfg_t cfg;

    erd_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg)
    );

    state_t state_reg, state_next;
    logic [15:0] token_reg;
    logic [7:0]  group_reg;
    logic [29:0] base_reg, base_next;
    logic [4:0]  i_reg, i_next;
    logic [31:0] w_reg, s0_reg;
    logic [31:0] sa_reg;
    logic [1:0]  lane_reg;
    logic        nib_hi_reg;
    logic        fw_reg;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic [12:0] element_reg;
    logic        last_reg, fault_reg;

    logic        accept, load_out;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [31:0] rdata;
    logic [13:0] len_eff;
    logic [12:0] start, e;
    logic [30:0] g, bq;
    logic [31:0] widx, blk, sa, sa1;
    logic [1:0]  lane;
    logic        scaled, fault;
    logic [7:0]  wbyte;
    logic [15:0] whalf, h;
    logic [3:0]  nib;
    logic signed [8:0] q;
    logic [31:0] value;
    logic        last;

    assign accept  = s_valid & s_ready;
    assign len_eff = (cfg.format_mode == FMT_Q4) ? {cfg.row_length[13:5], 5'd0}
                                                 : cfg.row_length;
    assign start   = {group_reg, 5'd0};
    assign e       = start + 13'(i_reg);
    assign g       = 31'(base_reg) + 31'(e);
    assign bq      = 31'(base_reg >> 1) + 31'({group_reg, 4'd0}) + 31'(i_reg[3:0]);
    assign scaled  = (cfg.format_mode == FMT_Q8) || (cfg.format_mode == FMT_Q4);

    // element addressing, used in the weight-read state
    always_comb begin
        case (cfg.format_mode)
            FMT_F32: begin widx = 32'(g);      lane = 2'd0;         end
            FMT_F16: begin widx = 32'(g >> 1); lane = {g[0], 1'b0}; end
            FMT_Q8:  begin widx = 32'(g >> 2); lane = g[1:0];       end
            default: begin widx = 32'(bq >> 2); lane = bq[1:0];     end
        endcase
        if (cfg.format_mode == FMT_Q4) begin
            blk = 32'(base_reg >> 5) + 32'(group_reg);
        end else begin
            blk = 32'(g >> 5);
        end
        sa = 32'(cfg.scale_base) + (blk << 1);
    end

    // decode, using weight word, low scale word and current read data
    assign sa1   = sa_reg + 32'd1;
    assign wbyte = 8'(w_reg >> {lane_reg, 3'b000});
    assign whalf = 16'(w_reg >> {lane_reg, 3'b000});
    assign h     = {8'(rdata >> {sa1[1:0], 3'b000}), 8'(s0_reg >> {sa_reg[1:0], 3'b000})};
    assign nib   = nib_hi_reg ? wbyte[7:4] : wbyte[3:0];
    assign fault = fw_reg | (scaled & (((sa_reg >> 2) >= SW) | ((sa1 >> 2) >= SW)));
    assign last  = ((14'(e) + 14'd1) == len_eff) || (i_reg == 5'd31);

    always_comb begin
        case (cfg.format_mode)
            FMT_F32: begin q = 9'sd0; value = w_reg; end
            FMT_F16: begin q = 9'sd1; value = scale_mul(q, whalf); end
            FMT_Q8:  begin q = {wbyte[7], wbyte}; value = scale_mul(q, h); end
            default: begin q = $signed({5'd0, nib}) - 9'sd8; value = scale_mul(q, h); end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        base_next  = base_reg;
        i_next     = i_reg;
        s_ready    = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = AW'(s_word_address);
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_action) begin
                        mem_we = (32'(s_word_address) < SW);
                    end else begin
                        state_next = ST_BASE;
                    end
                end
            end
            ST_BASE: begin
                base_next = 30'(token_reg * len_eff);
                i_next    = 5'd0;
                state_next = (14'(start) >= len_eff) ? ST_IDLE : ST_RDW;
            end
            ST_RDW: begin
                mem_re     = 1'b1;
                mem_addr   = widx[AW-1:0];
                state_next = ST_RDS0;
            end
            ST_RDS0: begin
                mem_re     = 1'b1;
                mem_addr   = sa_reg[AW+1:2];
                state_next = ST_RDS1;
            end
            ST_RDS1: begin
                mem_re     = 1'b1;
                mem_addr   = sa1[AW+1:2];
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!out_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    i_next   = i_reg + 5'd1;
                    state_next = last ? ST_IDLE : ST_RDW;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    erd_store #(.DEPTH(STORE_WORDS), .AW(AW)) u_store (
        .aclk(aclk), .we(mem_we), .re(mem_re), .addr(mem_addr),
        .wdata(s_word_data), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        i_reg    <= i_next;
        if (accept && !s_action) begin
            token_reg <= s_token;
            group_reg <= s_group;
        end
        if (state_reg == ST_RDW) begin
            sa_reg     <= sa;
            lane_reg   <= lane;
            nib_hi_reg <= i_reg[4];
            fw_reg     <= (widx >= SW);
        end
        if (state_reg == ST_RDS0) begin
            w_reg <= rdata;
        end
        if (state_reg == ST_RDS1) begin
            s0_reg <= rdata;
        end
        if (load_out) begin
            value_reg   <= fault ? 32'd0 : value;
            element_reg <= e;
            last_reg    <= last;
            fault_reg   <= fault;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_value   = value_reg;
    assign m_element = element_reg;
    assign m_last    = last_reg;
    assign m_fault   = fault_reg;

endmodule

// ----- rtl/erd_checker.sv -----
`include "assert_macros.svh"

module erd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_value,
    input logic [12:0] m_element,
    input logic        m_last,
    input logic        m_fault,
    input logic        pready
);

    `ASSERT_SAME(a_fault_zero, aclk, !aresetn, m_valid && m_fault, m_value == 32'd0)
    `ASSERT_NEXT(a_reset_idle, aclk, 1'b0, !aresetn, !m_valid)
    `ASSERT_SAME(a_pready_high, aclk, !aresetn, 1'b1, pready)
    `ASSERT_NEXT(a_stall_hold, aclk, !aresetn, m_valid && !m_ready,
                 m_valid && $stable(m_value) && $stable(m_element) && $stable(m_last))

endmodule

bind embedding_row_dequantizer erd_checker u_erd_checker (.*);
